// ----- rtl/assert_macros.svh -----
// Assertion macros used by the RTL file mrr_back.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ASSERT_IMPLIES(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed: same-cycle implication");
`define ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(lbl, pre, post)
`define ASSERT_NEXT(lbl, pre, post)
`endif

`endif

// ----- rtl/mrr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package mrr_pkg;

    localparam int FRAME_MAX_DEF = 256;
    localparam int IN_DEPTH = 4;
    localparam int OUT_DEPTH = 2;

    localparam logic [1:0] REQ_BYTE  = 2'd0;
    localparam logic [1:0] REQ_TICK  = 2'd1;
    localparam logic [1:0] REQ_START = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_TIMEOUT = 2'd1;
    localparam logic [1:0] ST_UNKNOWN = 2'd2;
    localparam logic [1:0] ST_CRC     = 2'd3;

    localparam logic [7:0]  FC_READ_HOLDING = 8'd3;
    localparam logic [7:0]  FC_READ_INPUT   = 8'd4;
    localparam logic [7:0]  FC_WRITE_SINGLE = 8'd6;
    localparam logic [7:0]  FC_WRITE_MULTI  = 8'd16;
    localparam logic [8:0]  LEN_WRITE       = 9'd8;
    localparam logic [8:0]  LEN_EXCEPTION   = 9'd5;
    localparam logic [8:0]  LEN_READ_BASE   = 9'd5;
    localparam logic [15:0] CRC_INIT        = 16'hFFFF;
    localparam logic [15:0] CRC_POLY        = 16'hA001;
    localparam logic [15:0] TIMEOUT_RESET   = 16'd1000;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] data_byte;
    } mrr_in_t;

    typedef struct packed {
        logic [1:0] status;
        logic [8:0] frame_length;
        logic [7:0] function_code;
        logic [7:0] third_byte;
    } mrr_out_t;

    typedef struct packed {
        logic       start;
        logic       tick;
        logic       byte_in;
        logic [7:0] data;
    } mrr_op_t;

    function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'd0, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/mrr_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mrr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             rd_en,
    output logic [WIDTH-1:0]      rd_data,
    output logic                  empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW:0]      wr_ptr_reg;
    logic [AW:0]      wr_ptr_next;
    logic [AW:0]      rd_ptr_reg;
    logic [AW:0]      rd_ptr_next;
    logic             do_wr;
    logic             do_rd;

    assign empty = (wr_ptr_reg == rd_ptr_reg);
    assign full  = (wr_ptr_reg[AW-1:0] == rd_ptr_reg[AW-1:0]) && (wr_ptr_reg[AW] != rd_ptr_reg[AW]);
    assign do_wr = wr_en && !full;
    assign do_rd = rd_en && !empty;
    assign rd_data = mem[rd_ptr_reg[AW-1:0]];
    assign wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
    assign rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg[AW-1:0]] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/mrr_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mrr_front
    import mrr_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire mrr_in_t cmd,
    output logic         full,
    output logic         op_valid,
    output mrr_op_t      op,
    input  wire logic    op_ready
);

    mrr_op_t op_in;
    logic    keep;
    logic    q_empty;

    always_comb
    begin
        op_in = '0;
        op_in.data = cmd.data_byte;
        keep = 1'b1;
        case (cmd.req_type)
            REQ_BYTE:  op_in.byte_in = 1'b1;
            REQ_TICK:  op_in.tick = 1'b1;
            REQ_START: op_in.start = 1'b1;
            default:   keep = 1'b0;
        endcase
    end

    // Undefined request types are dropped here; they never reach the back end.
    mrr_fifo #(
        .WIDTH($bits(mrr_op_t)),
        .DEPTH(IN_DEPTH)
    ) u_op_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push && keep),
        .wr_data (op_in),
        .full    (full),
        .rd_en   (op_ready),
        .rd_data (op),
        .empty   (q_empty)
    );

    assign op_valid = !q_empty;

endmodule

`default_nettype wire

// ----- rtl/mrr_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mrr_back
    import mrr_pkg::*;
#(
    parameter int FRAME_MAX = FRAME_MAX_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        op_valid,
    input  wire mrr_op_t     op,
    output logic             op_ready,
    output logic             res_push,
    output mrr_out_t         res,
    input  wire logic        res_full,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_data
);

    localparam logic [8:0] FrameMax9 = 9'(FRAME_MAX);

    logic        active_reg, active_next;
    logic [8:0]  bytes_seen_reg, bytes_seen_next;
    logic [8:0]  exp_len_reg, exp_len_next;
    logic [7:0]  func_reg, func_next;
    logic [7:0]  third_reg, third_next;
    logic [15:0] crc_reg, crc_next;
    logic [15:0] trail_reg, trail_next;
    logic [15:0] elapsed_reg, elapsed_next;
    logic [15:0] timeout_reg;
    logic        fire;
    logic        emit;
    logic        unknown;
    logic [1:0]  status_v;
    logic [8:0]  len_v;

    assign op_ready = !res_full;
    assign fire = op_valid && op_ready;

    always_comb
    begin
        active_next = active_reg;
        bytes_seen_next = bytes_seen_reg;
        exp_len_next = exp_len_reg;
        func_next = func_reg;
        third_next = third_reg;
        crc_next = crc_reg;
        trail_next = trail_reg;
        elapsed_next = elapsed_reg;
        emit = 1'b0;
        unknown = 1'b0;
        status_v = ST_OK;
        len_v = LEN_READ_BASE + {1'b0, op.data};
        if (fire)
        begin
            if (op.start)
            begin
                active_next = 1'b1;
                bytes_seen_next = '0;
                exp_len_next = '0;
                func_next = '0;
                third_next = '0;
                crc_next = CRC_INIT;
                trail_next = '0;
                elapsed_next = '0;
            end
            else if (active_reg && op.tick)
            begin
                if (elapsed_reg >= timeout_reg)
                begin
                    emit = 1'b1;
                    status_v = ST_TIMEOUT;
                end
                else
                begin
                    elapsed_next = elapsed_reg + 16'd1;
                end
            end
            else if (active_reg && op.byte_in)
            begin
                // The byte two places behind enters the CRC; the last two stay out.
                if (bytes_seen_reg >= 9'd2)
                begin
                    crc_next = crc16_feed(crc_reg, trail_reg[7:0]);
                end
                trail_next = {op.data, trail_reg[15:8]};
                if (bytes_seen_reg == 9'd1)
                begin
                    func_next = op.data;
                    bytes_seen_next = 9'd2;
                    if (op.data == FC_READ_HOLDING || op.data == FC_READ_INPUT)
                    begin
                        exp_len_next = exp_len_reg;
                    end
                    else if (op.data == FC_WRITE_SINGLE || op.data == FC_WRITE_MULTI)
                    begin
                        exp_len_next = LEN_WRITE;
                    end
                    else if (op.data[7])
                    begin
                        exp_len_next = LEN_EXCEPTION;
                    end
                    else
                    begin
                        unknown = 1'b1;
                    end
                end
                else if (bytes_seen_reg == 9'd2)
                begin
                    third_next = op.data;
                    bytes_seen_next = 9'd3;
                    if (func_reg == FC_READ_HOLDING || func_reg == FC_READ_INPUT)
                    begin
                        exp_len_next = (len_v > FrameMax9) ? FrameMax9 : len_v;
                    end
                end
                else if (bytes_seen_reg != 9'h1FF)
                begin
                    bytes_seen_next = bytes_seen_reg + 9'd1;
                end

                if (unknown)
                begin
                    emit = 1'b1;
                    status_v = ST_UNKNOWN;
                end
                else if (exp_len_next != 9'd0 && bytes_seen_next >= exp_len_next)
                begin
                    emit = 1'b1;
                    status_v = (trail_next == crc_next) ? ST_OK : ST_CRC;
                end
            end
        end
        if (emit)
        begin
            active_next = 1'b0;
        end
    end

    assign res_push = emit;
    assign res = '{status: status_v, frame_length: bytes_seen_next,
                   function_code: func_next, third_byte: third_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            bytes_seen_reg <= '0;
            exp_len_reg <= '0;
            func_reg <= '0;
            third_reg <= '0;
            crc_reg <= CRC_INIT;
            trail_reg <= '0;
            elapsed_reg <= '0;
            timeout_reg <= TIMEOUT_RESET;
        end
        else
        begin
            active_reg <= active_next;
            bytes_seen_reg <= bytes_seen_next;
            exp_len_reg <= exp_len_next;
            func_reg <= func_next;
            third_reg <= third_next;
            crc_reg <= crc_next;
            trail_reg <= trail_next;
            elapsed_reg <= elapsed_next;
            if (cfg_we)
            begin
                timeout_reg <= cfg_data;
            end
        end
    end

`include "assert_macros.svh"

    `ASSERT_IMPLIES(a_result_only_when_active, res_push, active_reg && fire)
    `ASSERT_NEXT(a_start_opens_frame, fire && op.start, active_reg && bytes_seen_reg == 9'd0)
    `ASSERT_IMPLIES(a_length_bounded, active_reg, bytes_seen_reg <= FrameMax9)
    `ASSERT_IMPLIES(a_ok_has_full_frame, res_push && res.status == ST_OK,
                    res.frame_length >= LEN_EXCEPTION)

endmodule

`default_nettype wire

// ----- rtl/modbus_rtu_response_receiver.sv -----
// An accepted item is classified into a four-entry queue; the back end executes
// the queue head and writes any result into the result queue, for popping.
// Throughput: one item per cycle while the result queue has room, set by the
// combinational CRC and counter update. The result queue holds two results;
// the back end stalls only when it is full. Reset (rst_n low, asynchronous)
// empties both queues, idles the receiver and sets the timeout to 1000 ms.
`timescale 1ns / 1ps
`default_nettype none

module modbus_rtu_response_receiver
    import mrr_pkg::*;
#(
    parameter int FRAME_MAX = FRAME_MAX_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire mrr_in_t     cmd,
    output logic             full,
    output logic             empty,
    input  wire logic        pop,
    output mrr_out_t         result,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_data
);

    logic     op_valid;
    logic     op_ready;
    mrr_op_t  op;
    logic     res_push;
    logic     res_full;
    mrr_out_t res;

    mrr_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .cmd      (cmd),
        .full     (full),
        .op_valid (op_valid),
        .op       (op),
        .op_ready (op_ready)
    );

    mrr_back #(
        .FRAME_MAX(FRAME_MAX)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_valid (op_valid),
        .op       (op),
        .op_ready (op_ready),
        .res_push (res_push),
        .res      (res),
        .res_full (res_full),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    mrr_fifo #(
        .WIDTH($bits(mrr_out_t)),
        .DEPTH(OUT_DEPTH)
    ) u_res_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (result),
        .empty   (empty)
    );

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import mrr_pkg::*;

    localparam logic [1:0] REQ_NONE = 2'd3;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASES = 6;
    localparam mrr_out_t NO_STATUS = '0;

    typedef enum logic [1:0] {DS_LIT, DS_RAND, DS_CRC_LO, DS_CRC_HI} byte_src_e;

    typedef struct {
        logic [1:0] req;
        byte_src_e  src;
        logic [7:0] val;
        int         reps;
        bit         fixed;
        mrr_out_t   want;
    } plan_row_t;

    logic       clk;
    logic       rst_n;
    logic       push;
    mrr_in_t    cmd;
    logic       full;
    logic       empty;
    logic       pop;
    mrr_out_t   result;
    logic       cfg_we;
    logic [15:0] cfg_data;

    logic        rx_busy;
    logic [8:0]  rx_count;
    logic [8:0]  rx_len;
    logic [7:0]  rx_fc;
    logic [7:0]  rx_third;
    logic [15:0] rx_crc;
    logic [15:0] rx_tail;
    logic [15:0] rx_ms;
    logic [15:0] rx_timeout;

    mrr_out_t    status_due[$];
    mrr_out_t    due_head;
    logic [15:0] tx_crc;
    int          live_items;
    int          errors;
    int          idle_odds;
    int          stall_odds;
    int          stall_left;
    int          quiet_cycles;

    plan_row_t plan_tbl[$] = '{
        '{REQ_BYTE,  DS_LIT,    8'hA5, 1,    1'b0, NO_STATUS},
        '{REQ_TICK,  DS_LIT,    8'h00, 1,    1'b0, NO_STATUS},
        '{REQ_NONE,  DS_LIT,    8'hFF, 1,    1'b0, NO_STATUS},
        '{REQ_START, DS_LIT,    8'h00, 1,    1'b0, NO_STATUS},
        '{REQ_BYTE,  DS_LIT,    8'h00, 1,    1'b0, NO_STATUS},
        '{REQ_BYTE,  DS_LIT,    8'h01, 1,    1'b1, '{ST_UNKNOWN, 9'd2, 8'h01, 8'h00}},
        '{REQ_START, DS_LIT,    8'h00, 1,    1'b0, NO_STATUS},
        '{REQ_BYTE,  DS_LIT,    8'hFF, 1,    1'b0, NO_STATUS},
        '{REQ_BYTE,  DS_LIT,    8'h83, 1,    1'b0, NO_STATUS},
        '{REQ_BYTE,  DS_LIT,    8'h02, 1,    1'b0, NO_STATUS},
        '{REQ_BYTE,  DS_CRC_LO, 8'h00, 1,    1'b0, NO_STATUS},
        '{REQ_BYTE,  DS_CRC_HI, 8'h00, 1,    1'b1, '{ST_OK, 9'd5, 8'h83, 8'h02}},
        '{REQ_START, DS_LIT,    8'h00, 1,    1'b0, NO_STATUS},
        '{REQ_BYTE,  DS_LIT,    8'h01, 1,    1'b0, NO_STATUS},
        '{REQ_BYTE,  DS_LIT,    8'h06, 1,    1'b0, NO_STATUS},
        '{REQ_BYTE,  DS_LIT,    8'h00, 1,    1'b0, NO_STATUS},
        '{REQ_BYTE,  DS_LIT,    8'h01, 1,    1'b0, NO_STATUS},
        '{REQ_BYTE,  DS_LIT,    8'h00, 1,    1'b0, NO_STATUS},
        '{REQ_BYTE,  DS_LIT,    8'h03, 1,    1'b0, NO_STATUS},
        '{REQ_BYTE,  DS_LIT,    8'h00, 2,    1'b1, '{ST_CRC, 9'd8, 8'h06, 8'h00}},
        '{REQ_START, DS_LIT,    8'h00, 1,    1'b0, NO_STATUS},
        '{REQ_BYTE,  DS_LIT,    8'h11, 1,    1'b0, NO_STATUS},
        '{REQ_BYTE,  DS_LIT,    8'h10, 1,    1'b0, NO_STATUS},
        '{REQ_BYTE,  DS_RAND,   8'h00, 4,    1'b0, NO_STATUS},
        '{REQ_BYTE,  DS_CRC_LO, 8'h00, 1,    1'b0, NO_STATUS},
        '{REQ_BYTE,  DS_CRC_HI, 8'h00, 1,    1'b0, NO_STATUS},
        '{REQ_START, DS_LIT,    8'h00, 1,    1'b0, NO_STATUS},
        '{REQ_BYTE,  DS_LIT,    8'h01, 1,    1'b0, NO_STATUS},
        '{REQ_BYTE,  DS_LIT,    8'h03, 1,    1'b0, NO_STATUS},
        '{REQ_BYTE,  DS_LIT,    8'hFF, 1,    1'b0, NO_STATUS},
        '{REQ_BYTE,  DS_RAND,   8'h00, 251,  1'b0, NO_STATUS},
        '{REQ_BYTE,  DS_CRC_LO, 8'h00, 1,    1'b0, NO_STATUS},
        '{REQ_BYTE,  DS_CRC_HI, 8'h00, 1,    1'b1, '{ST_OK, 9'd256, 8'h03, 8'hFF}},
        '{REQ_START, DS_LIT,    8'h00, 1,    1'b0, NO_STATUS},
        '{REQ_BYTE,  DS_LIT,    8'h01, 1,    1'b0, NO_STATUS},
        '{REQ_BYTE,  DS_LIT,    8'h04, 1,    1'b0, NO_STATUS},
        '{REQ_BYTE,  DS_LIT,    8'h00, 1,    1'b0, NO_STATUS},
        '{REQ_BYTE,  DS_CRC_LO, 8'h00, 1,    1'b0, NO_STATUS},
        '{REQ_BYTE,  DS_CRC_HI, 8'h00, 1,    1'b1, '{ST_OK, 9'd5, 8'h04, 8'h00}},
        '{REQ_START, DS_LIT,    8'h00, 1,    1'b0, NO_STATUS},
        '{REQ_BYTE,  DS_LIT,    8'h01, 1,    1'b0, NO_STATUS},
        '{REQ_BYTE,  DS_LIT,    8'h03, 1,    1'b0, NO_STATUS},
        '{REQ_START, DS_LIT,    8'h00, 1,    1'b0, NO_STATUS},
        '{REQ_BYTE,  DS_LIT,    8'h01, 1,    1'b0, NO_STATUS},
        '{REQ_BYTE,  DS_LIT,    8'h04, 1,    1'b0, NO_STATUS},
        '{REQ_BYTE,  DS_LIT,    8'h02, 1,    1'b0, NO_STATUS},
        '{REQ_TICK,  DS_RAND,   8'h00, 21,   1'b1, '{ST_TIMEOUT, 9'd3, 8'h04, 8'h02}},
        '{REQ_BYTE,  DS_LIT,    8'h55, 1,    1'b0, NO_STATUS}
    };

    modbus_rtu_response_receiver DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .cmd      (cmd),
        .full     (full),
        .empty    (empty),
        .pop      (pop),
        .result   (result),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] acc;
        acc = crc ^ {8'h00, b};
        repeat (8)
        begin
            acc = acc[0] ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
        end
        return acc;
    endfunction

    function automatic void open_frame();
        rx_count = '0;
        rx_len   = '0;
        rx_fc    = '0;
        rx_third = '0;
        rx_crc   = CRC_INIT;
        rx_tail  = '0;
        rx_ms    = '0;
    endfunction

    function automatic mrr_out_t close_frame(input logic [1:0] st);
        mrr_out_t res;
        res.status        = st;
        res.frame_length  = rx_count;
        res.function_code = rx_fc;
        res.third_byte    = rx_third;
        rx_busy = 1'b0;
        return res;
    endfunction

    function automatic bit predict_status(input mrr_in_t it, output mrr_out_t res);
        logic [7:0] b;
        int span;
        b = it.data_byte;
        res = '0;
        if (it.req_type == REQ_START)
        begin
            open_frame();
            rx_busy = 1'b1;
            return 1'b0;
        end
        if (!rx_busy || it.req_type == REQ_NONE)
            return 1'b0;
        if (it.req_type == REQ_TICK)
        begin
            if (rx_ms >= rx_timeout)
            begin
                res = close_frame(ST_TIMEOUT);
                return 1'b1;
            end
            rx_ms = rx_ms + 16'd1;
            return 1'b0;
        end
        // The CRC runs two bytes behind, so the last two are left for comparison.
        if (rx_count >= 9'd2)
            rx_crc = crc16_step(rx_crc, rx_tail[7:0]);
        rx_tail = {b, rx_tail[15:8]};
        if (rx_count == 9'd1)
        begin
            rx_fc = b;
            rx_count = 9'd2;
            if (b == FC_READ_HOLDING || b == FC_READ_INPUT)
                rx_len = rx_len;
            else if (b == FC_WRITE_SINGLE || b == FC_WRITE_MULTI)
                rx_len = LEN_WRITE;
            else if (b[7])
                rx_len = LEN_EXCEPTION;
            else
            begin
                res = close_frame(ST_UNKNOWN);
                return 1'b1;
            end
        end
        else if (rx_count == 9'd2)
        begin
            rx_third = b;
            rx_count = 9'd3;
            if (rx_fc == FC_READ_HOLDING || rx_fc == FC_READ_INPUT)
            begin
                span = int'(LEN_READ_BASE) + int'(b);
                rx_len = (span > FRAME_MAX_DEF) ? 9'(FRAME_MAX_DEF) : 9'(span);
            end
        end
        else if (rx_count < 9'h1FF)
            rx_count = rx_count + 9'd1;
        if (rx_len != 9'd0 && rx_count >= rx_len)
        begin
            res = close_frame((rx_tail == rx_crc) ? ST_OK : ST_CRC);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic issue(input logic [1:0] req, input logic [7:0] data, input bit fixed,
                         input mrr_out_t fixed_res);
        mrr_in_t  it;
        mrr_out_t got;
        bit       has;
        it.req_type  = req;
        it.data_byte = data;
        if ($urandom_range(0, 99) < idle_odds)
        begin
            push = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        push = 1'b1;
        cmd = it;
        @(posedge clk);
        while (full)
            @(posedge clk);
        if (req == REQ_START || (rx_busy && req != REQ_NONE))
            live_items++;
        has = predict_status(it, got);
        if (fixed)
            status_due.push_back(fixed_res);
        else if (has)
            status_due.push_back(got);
        if (req == REQ_START)
            tx_crc = CRC_INIT;
        else if (req == REQ_BYTE)
            tx_crc = crc16_step(tx_crc, data);
        @(negedge clk);
    endtask

    task automatic tick_burst(input int n);
        repeat (n) issue(REQ_TICK, 8'($urandom_range(0, 255)), 1'b0, NO_STATUS);
    endtask

    task automatic send_frame();
        logic [7:0]  body[$];
        logic [7:0]  fc;
        logic [7:0]  bc;
        logic [15:0] fcs;
        int kind;
        int total;
        int cut;
        int i;
        total = 0;
        body.push_back(8'($urandom_range(0, 255)));
        kind = $urandom_range(0, 99);
        if (kind < 35)
        begin
            fc = $urandom_range(0, 1) ? FC_READ_HOLDING : FC_READ_INPUT;
            bc = ($urandom_range(0, 79) == 0) ? 8'($urandom_range(248, 255))
                                              : 8'($urandom_range(0, 12));
            total = (5 + int'(bc) > FRAME_MAX_DEF) ? FRAME_MAX_DEF : 5 + int'(bc);
            body.push_back(fc);
            body.push_back(bc);
        end
        else if (kind < 60)
        begin
            fc = $urandom_range(0, 1) ? FC_WRITE_SINGLE : FC_WRITE_MULTI;
            total = int'(LEN_WRITE);
            body.push_back(fc);
        end
        else if (kind < 85)
        begin
            fc = 8'h80 | 8'($urandom_range(0, 127));
            total = int'(LEN_EXCEPTION);
            body.push_back(fc);
        end
        else
        begin
            do
                fc = 8'($urandom_range(0, 127));
            while (fc == FC_READ_HOLDING || fc == FC_READ_INPUT ||
                   fc == FC_WRITE_SINGLE || fc == FC_WRITE_MULTI);
            body.push_back(fc);
            repeat ($urandom_range(0, 2)) body.push_back(8'($urandom_range(0, 255)));
        end
        if (total != 0)
        begin
            while (body.size() < total - 2)
                body.push_back(8'($urandom_range(0, 255)));
            fcs = CRC_INIT;
            for (i = 0; i < body.size(); i++)
                fcs = crc16_step(fcs, body[i]);
            if ($urandom_range(0, 7) == 0)
                fcs = fcs ^ (16'd1 << $urandom_range(0, 15));
            body.push_back(fcs[7:0]);
            body.push_back(fcs[15:8]);
        end
        cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, body.size() - 1) : body.size();
        issue(REQ_START, 8'($urandom_range(0, 255)), 1'b0, NO_STATUS);
        for (i = 0; i < cut; i++)
        begin
            if ($urandom_range(0, 3) == 0)
                tick_burst($urandom_range(1, 3));
            if ($urandom_range(0, 29) == 0)
                issue(REQ_NONE, 8'($urandom_range(0, 255)), 1'b0, NO_STATUS);
            issue(REQ_BYTE, body[i], 1'b0, NO_STATUS);
        end
        if (cut < body.size() && rx_timeout < 16'd64)
            tick_burst(int'(rx_timeout) + 1);
    endtask

    task automatic settle();
        push = 1'b0;
        while (status_due.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    task automatic set_timeout(input logic [15:0] ms);
        cfg_we = 1'b1;
        cfg_data = ms;
        @(negedge clk);
        cfg_we = 1'b0;
        rx_timeout = ms;
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            errors++;
        end
    endtask

    always @(negedge clk)
    begin
        if (!rst_n)
            pop = 1'b0;
        else if (stall_left > 0)
        begin
            pop = 1'b0;
            stall_left--;
        end
        else if ($urandom_range(0, 99) < stall_odds)
        begin
            pop = 1'b0;
            stall_left = $urandom_range(0, 7);
        end
        else
            pop = 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (status_due.size() == 0)
            begin
                $error("unexpected item: status %0d length %0d code %0d third %0d",
                       result.status, result.frame_length, result.function_code,
                       result.third_byte);
                errors++;
            end
            else
            begin
                due_head = status_due.pop_front();
                check_field("status", due_head.status, result.status);
                check_field("frame_length", due_head.frame_length, result.frame_length);
                check_field("function_code", due_head.function_code, result.function_code);
                check_field("third_byte", due_head.third_byte, result.third_byte);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                quiet_cycles = 0;
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("status: fail");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        logic [15:0] phase_ms[PHASES];
        plan_row_t   row;
        logic [15:0] fcs;
        logic [7:0]  data;
        int p;
        int r;
        int goal;
        rst_n = 1'b0;
        push = 1'b0;
        cmd = '0;
        pop = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        errors = 0;
        live_items = 0;
        quiet_cycles = 0;
        stall_left = 0;
        idle_odds = 15;
        stall_odds = 15;
        tx_crc = CRC_INIT;
        fcs = CRC_INIT;
        rx_timeout = TIMEOUT_RESET;
        rx_busy = 1'b0;
        open_frame();
        phase_ms[0] = 16'd0;
        phase_ms[1] = 16'd1;
        phase_ms[2] = 16'hFFFF;
        phase_ms[3] = 16'd6;
        phase_ms[4] = 16'($urandom_range(1, 65535));
        phase_ms[5] = 16'd25;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        set_timeout(16'd20);

        foreach (plan_tbl[i])
        begin
            row = plan_tbl[i];
            for (r = 0; r < row.reps; r++)
            begin
                if (row.src == DS_CRC_LO)
                    fcs = tx_crc;
                case (row.src)
                    DS_LIT:    data = row.val;
                    DS_RAND:   data = 8'($urandom_range(0, 255));
                    DS_CRC_LO: data = fcs[7:0];
                    default:   data = fcs[15:8];
                endcase
                issue(row.req, data, row.fixed && r == row.reps - 1, row.want);
            end
        end

        for (p = 0; p < PHASES; p++)
        begin
            settle();
            set_timeout(phase_ms[p]);
            if (p == PHASES - 1)
            begin
                idle_odds = 0;
                stall_odds = 0;
            end
            else
            begin
                idle_odds = $urandom_range(0, 2) * 15;
                stall_odds = $urandom_range(0, 2) * 15;
            end
            goal = live_items + 70;
            while (live_items < goal)
            begin
                if ($urandom_range(0, 5) == 0)
                    repeat ($urandom_range(1, 3))
                        issue(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                              1'b0, NO_STATUS);
                send_frame();
            end
        end

        push = 1'b0;
        while (status_due.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        if (errors == 0 && status_due.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
